// ===== rtl/band_rank_select_assert.svh =====
// ----------------------------------------------------------------------------
// band_rank_select assertion macros
// Shared assertion forms for the rank selection checker.
// ----------------------------------------------------------------------------
`ifndef BAND_RANK_SELECT_ASSERT_SVH
`define BAND_RANK_SELECT_ASSERT_SVH

// Delayed form: the consequent must hold after the antecedent.
`define BRS_ASSERT_DLY2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Types and constants shared by the rank selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

	localparam int INPUTS    = 8;
	localparam int ELEM_BITS = 32;
	localparam int POS_W     = $clog2(INPUTS);
	localparam int CNT_W     = $clog2(INPUTS + 1);
	localparam int CFG_W     = 4;
	localparam int IDX_W     = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_NUM_INPUTS  = 2'd0,
		REG_RANK_PICK   = 2'd1,
		REG_SIGNED_MODE = 2'd2
	} cfg_reg_t;

	typedef logic [ELEM_BITS-1:0] elem_t;
	typedef elem_t [INPUTS-1:0] elem_vec_t;

	typedef struct packed {
		logic [31:0] value_0;
		logic [31:0] value_1;
		logic [31:0] value_2;
		logic [31:0] value_3;
		logic [31:0] value_4;
		logic [31:0] value_5;
		logic [31:0] value_6;
		logic [31:0] value_7;
		logic        line_end_in;
	} req_t;

	typedef struct packed {
		logic [31:0] ranked_value;
		logic        line_end_out;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [POS_W-1:0] pick;
		logic             signed_mode;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/band_rank_select.sv =====
// ----------------------------------------------------------------------------
// band_rank_select
// Rank-order selection across the co-located elements of up to eight images.
// ----------------------------------------------------------------------------
// One request is taken every cycle; busy never rises. Each request is
// registered, ranked in the eight parallel ranking lanes, registered again
// and merged onto result with done high in the merge stage. The
// result is shown for a single cycle and cannot be held off, so the receiver
// must take it when done is high. Write the registers only while no request
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module band_rank_select (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  brs_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [brs_pkg::IDX_W-1:0]     cfg_index,
	input  logic [brs_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          done,
	output brs_pkg::result_t              result
);
	import brs_pkg::*;

	logic [3:0]       num_inputs_q;
	logic [2:0]       rank_pick_q;
	logic             signed_mode_q;

	logic             accept;
	ctl_t             ctl;
	logic [CNT_W-1:0] cnt;
	elem_vec_t        vals_in;

	logic             valid_s1;
	elem_vec_t        vals_s1;
	logic             line_end_s1;
	ctl_t             ctl_s1;

	logic [INPUTS-1:0] hits;
	logic              valid_s2;
	logic [INPUTS-1:0] hits_s2;
	elem_vec_t         vals_s2;
	logic              line_end_s2;

	elem_t             sel;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_inputs_q  <= 4'd8;
			rank_pick_q   <= 3'd4;
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_INPUTS:  num_inputs_q  <= cfg_wdata;
				REG_RANK_PICK:   rank_pick_q   <= cfg_wdata[2:0];
				REG_SIGNED_MODE: signed_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamp count to 1..INPUTS and rank to count-1
	always_comb begin
		if ({1'b0, num_inputs_q} > 5'(INPUTS)) begin
			cnt = CNT_W'(INPUTS);
		end else if (num_inputs_q == 4'd0) begin
			cnt = CNT_W'(1);
		end else begin
			cnt = CNT_W'(num_inputs_q);
		end
		ctl.cnt         = cnt;
		ctl.signed_mode = signed_mode_q;
		if ({1'b0, rank_pick_q} > (cnt - 1'b1)) begin
			ctl.pick = POS_W'(cnt - 1'b1);
		end else begin
			ctl.pick = rank_pick_q;
		end
	end

	assign vals_in[0] = req.value_0;
	assign vals_in[1] = req.value_1;
	assign vals_in[2] = req.value_2;
	assign vals_in[3] = req.value_3;
	assign vals_in[4] = req.value_4;
	assign vals_in[5] = req.value_5;
	assign vals_in[6] = req.value_6;
	assign vals_in[7] = req.value_7;

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			vals_s1     <= vals_in;
			line_end_s1 <= req.line_end_in;
			ctl_s1      <= ctl;
		end
		if (valid_s1) begin
			hits_s2     <= hits;
			vals_s2     <= vals_s1;
			line_end_s2 <= line_end_s1;
		end
	end

	for (genvar g = 0; g < INPUTS; g++) begin : g_lane
		brs_lane u_lane (
			.vals     (vals_s1),
			.ctl      (ctl_s1),
			.lane_idx (POS_W'(g)),
			.hit      (hits[g])
		);
	end

	brs_merge u_merge (
		.hits (hits_s2),
		.vals (vals_s2),
		.sel  (sel)
	);

	assign done   = valid_s2;
	assign result = {sel, line_end_s2};

endmodule

`default_nettype wire

// ===== rtl/brs_lane.sv =====
// ----------------------------------------------------------------------------
// brs_lane
// Ranks one element against the other active elements (the first cnt) and
// flags it when it sits at the requested rank.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_lane (
	input  brs_pkg::elem_vec_t              vals,
	input  brs_pkg::ctl_t                   ctl,
	input  logic [brs_pkg::POS_W-1:0]       lane_idx,
	output logic                            hit
);
	import brs_pkg::*;

	elem_t            flip;
	elem_t            own;
	logic [POS_W-1:0] pos;

	assign flip = ctl.signed_mode ? {1'b1, {(ELEM_BITS-1){1'b0}}} : '0;
	assign own  = vals[lane_idx] ^ flip;

	always_comb begin
		elem_t other;
		logic  less;
		pos = '0;
		for (int j = 0; j < INPUTS; j++) begin
			other = vals[j] ^ flip;
			less  = (other < own) || ((other == own) && (POS_W'(j) < lane_idx));
			if ((CNT_W'(j) < ctl.cnt) && less) begin
				pos = pos + 1'b1;
			end
		end
	end

	assign hit = ({1'b0, lane_idx} < ctl.cnt) && (pos == ctl.pick);

endmodule

`default_nettype wire

// ===== rtl/brs_merge.sv =====
// ----------------------------------------------------------------------------
// brs_merge
// Combines the lane flags into the single selected element.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_merge (
	input  logic [brs_pkg::INPUTS-1:0] hits,
	input  brs_pkg::elem_vec_t         vals,
	output brs_pkg::elem_t             sel
);
	import brs_pkg::*;

	always_comb begin
		sel = '0;
		for (int i = 0; i < INPUTS; i++) begin
			sel = sel | (vals[i] & {ELEM_BITS{hits[i]}});
		end
	end

endmodule

`default_nettype wire

// ===== rtl/brs_check.sv =====
// ----------------------------------------------------------------------------
// brs_check
// Port-level checks on request to result timing and selection.
// ----------------------------------------------------------------------------
`default_nettype none

`include "band_rank_select_assert.svh"

module brs_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  brs_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [brs_pkg::IDX_W-1:0]     cfg_index,
	input  logic [brs_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          done,
	input  brs_pkg::result_t              result
);
	import brs_pkg::*;

	logic taken;
	logic all_eq;
	logic cfg_idle;

	assign taken    = start && !busy;
	assign cfg_idle = !(cfg_we && (cfg_index != '0 || cfg_wdata != '0)) || 1'b1;
	assign all_eq   = (req.value_0 == req.value_1) && (req.value_0 == req.value_2) &&
		(req.value_0 == req.value_3) && (req.value_0 == req.value_4) &&
		(req.value_0 == req.value_5) && (req.value_0 == req.value_6) &&
		(req.value_0 == req.value_7);

	`BRS_ASSERT_DLY2(a_done_follows, taken, done, "result missing two cycles after request")
	`BRS_ASSERT_DLY2(a_no_spurious, !taken && cfg_idle, !done, "result without a request")
	`BRS_ASSERT_DLY2(a_line_end, taken, result.line_end_out == $past(req.line_end_in, 2), "line end flag lost")
	`BRS_ASSERT_DLY2(a_equal_sel, taken && all_eq, result.ranked_value == $past(req.value_0, 2), "equal elements gave another value")

endmodule

bind band_rank_select brs_check u_brs_check (.*);

`default_nettype wire
